FILE: rtl/pesp_pkg.sv
// pesp_pkg: types, phase codes and helpers for the pes header parser
// used by all rtl files of the block; no dependencies

package pesp_pkg;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       first_byte;
    } pesp_in_t;

    typedef struct packed {
        logic [7:0]  pes_sid;
        logic [15:0] pkt_len;
        logic [1:0]  syntax_version;
        logic [13:0] header_flags;
        logic [7:0]  header_data_length;
        logic [32:0] pts;
        logic [32:0] dts;
        logic [32:0] clkref_base;
        logic [8:0]  clkref_ext;
        logic [21:0] es_rate;
        logic [23:0] trick_and_crc;
        logic [1:0]  status;
    } pesp_out_t;

    // one-hot parse phases; bit order is the order of the header groups
    typedef enum logic [26:0] {
        PH_IDLE     = 27'h0000001,
        PH_SC1      = 27'h0000002,
        PH_SC2      = 27'h0000004,
        PH_SID      = 27'h0000008,
        PH_LENH     = 27'h0000010,
        PH_LENL     = 27'h0000020,
        PH_OPT0     = 27'h0000040,
        PH_OPT1     = 27'h0000080,
        PH_HDL      = 27'h0000100,
        PH_PTS      = 27'h0000200,
        PH_DTS      = 27'h0000400,
        PH_ESCR     = 27'h0000800,
        PH_RATE     = 27'h0001000,
        PH_TRICK    = 27'h0002000,
        PH_COPY     = 27'h0004000,
        PH_CRC      = 27'h0008000,
        PH_EXT      = 27'h0010000,
        PH_PRIV     = 27'h0020000,
        PH_PACKLEN  = 27'h0040000,
        PH_PACKSKIP = 27'h0080000,
        PH_SEQ      = 27'h0100000,
        PH_PSTD     = 27'h0200000,
        PH_EXT2LEN  = 27'h0400000,
        PH_EXT2SKIP = 27'h0800000,
        PH_M1A      = 27'h1000000,
        PH_M1STD    = 27'h2000000,
        PH_M1C      = 27'h4000000
    } pesp_phase_t;

    localparam logic [1:0] ST_OK      = 2'd0;
    localparam logic [1:0] ST_MARKER  = 2'd1;
    localparam logic [1:0] ST_NOOPT   = 2'd2;

    localparam logic [1:0] VER_NONE   = 2'd0;
    localparam logic [1:0] VER_MPEG1  = 2'd1;
    localparam logic [1:0] VER_MPEG2  = 2'd2;

    // bytes per field group
    function automatic logic [4:0] group_len(input pesp_phase_t p);
        case (p)
            PH_PTS, PH_DTS:              group_len = 5'd5;
            PH_ESCR:                     group_len = 5'd6;
            PH_RATE:                     group_len = 5'd3;
            PH_TRICK, PH_COPY, PH_EXT,
            PH_PACKLEN, PH_EXT2LEN:      group_len = 5'd1;
            PH_CRC, PH_SEQ, PH_PSTD:     group_len = 5'd2;
            PH_PRIV:                     group_len = 5'd16;
            default:                     group_len = 5'd0;
        endcase
    endfunction

    function automatic logic regular_stream(input logic [7:0] sid);
        regular_stream = !(sid inside {8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2,
                                       8'hF8, 8'hFF});
    endfunction

    function automatic logic [7:0] hdl_sat(input logic [7:0] a, input logic [3:0] n);
        logic [8:0] s;
        s = {1'b0, a} + {5'd0, n};
        hdl_sat = s[8] ? 8'hFF : s[7:0];
    endfunction

endpackage

FILE: rtl/pesp_out_reg.sv
// pesp_out_reg: result register with valid/ready between parser and sink
// depends on pesp_pkg

module pesp_out_reg (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 load,
    input  pesp_pkg::pesp_out_t  load_data,
    output logic                 full,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pesp_pkg::pesp_out_t  m_data
);
    import pesp_pkg::*;

    logic      valid_reg;
    pesp_out_t data_reg;

    // hold one result beat until taken
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (load) begin
            valid_reg <= 1'b1;
        end else if (m_ready) begin
            valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (load) begin
            data_reg <= load_data;
        end
    end

    assign full    = valid_reg && !m_ready;
    assign m_valid = valid_reg;
    assign m_data  = data_reg;

endmodule

FILE: rtl/pesp_parser.sv
// pesp_parser: byte-serial parse state and field accumulators
// depends on pesp_pkg

module pesp_parser (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 beat,
    input  pesp_pkg::pesp_in_t   in_data,
    output logic                 emit,
    output pesp_pkg::pesp_out_t  emit_data
);
    import pesp_pkg::*;

    pesp_phase_t phase_reg, phase_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [7:0]  skip_reg, skip_next;
    logic [47:0] shift_reg, shift_next;
    logic [13:0] flags_reg, flags_next;
    logic [7:0]  ext_reg, ext_next;
    logic [7:0]  sid_reg, sid_next;
    logic [15:0] len_reg, len_next;
    logic [1:0]  ver_reg, ver_next;
    logic [7:0]  hdl_reg, hdl_next;
    logic [7:0]  trick_reg, trick_next;
    logic [15:0] crc_reg, crc_next;
    logic [32:0] pts_reg, pts_next;
    logic [32:0] dts_reg, dts_next;
    logic [32:0] escr_reg, escr_next;
    logic [8:0]  escx_reg, escx_next;
    logic [21:0] rate_reg, rate_next;

    logic [7:0]  b;
    logic [47:0] x;
    logic [4:0]  cnt_inc;
    logic [1:0]  pd;
    logic        group_end;
    logic        go_next;
    pesp_phase_t go_from;
    logic [1:0]  st;
    logic        m1_flag;
    logic [7:0]  hdl_m1;
    logic [1:0]  m1pd;
    logic [3:0]  ts_nib;
    logic        ts_ok;
    logic [32:0] ts_val;
    logic [7:0]  skip_dec;

    // which group comes next after a given phase, from flags in hand
    function automatic pesp_phase_t next_phase(input pesp_phase_t from,
                                               input logic [13:0] fl,
                                               input logic [7:0] ef,
                                               input logic [7:0] sk,
                                               output logic none);
        logic [26:0] want;
        logic [26:0] fv;
        logic [26:0] above;
        logic [26:0] cand;
        want = '0;
        if (fl[7])          want = want | PH_PTS;
        if (fl[7] && fl[6]) want = want | PH_DTS;
        if (fl[5])          want = want | PH_ESCR;
        if (fl[4])          want = want | PH_RATE;
        if (fl[3])          want = want | PH_TRICK;
        if (fl[2])          want = want | PH_COPY;
        if (fl[1])          want = want | PH_CRC;
        if (fl[0])          want = want | PH_EXT;
        if (ef[7])          want = want | PH_PRIV;
        if (ef[6])          want = want | PH_PACKLEN;
        if (sk != 8'd0)     want = want | PH_PACKSKIP;
        if (ef[5])          want = want | PH_SEQ;
        if (ef[4])          want = want | PH_PSTD;
        if (ef[0])          want = want | PH_EXT2LEN;
        if (sk != 8'd0)     want = want | PH_EXT2SKIP;
        // lowest wanted phase above the current one
        fv    = from;
        above = ~({fv[25:0], 1'b0} - 27'd1);
        cand  = want & above;
        none  = (cand == '0);
        next_phase = pesp_phase_t'(cand & (~cand + 27'd1));
    endfunction

    assign b        = in_data.data_byte;
    assign x        = {shift_reg[39:0], b};
    assign cnt_inc  = cnt_reg + 5'd1;
    assign pd       = flags_reg[7:6];
    assign skip_dec = (skip_reg != 8'd0) ? skip_reg - 8'd1 : 8'd0;

    // timestamp check and decode for pts/dts groups
    assign ts_nib = (phase_reg == PH_DTS) ? 4'd1 : {2'b00, pd};
    assign ts_ok  = x[39:36] == ts_nib && x[32] && x[16] && x[0];
    assign ts_val = {x[35:33], x[31:17], x[15:1]};

    // mpeg-1 flag byte helpers
    assign m1pd   = b[5:4];

    always_comb begin
        logic        none;
        pesp_phase_t np;
        phase_next = phase_reg;
        cnt_next   = cnt_reg;
        skip_next  = skip_reg;
        shift_next = shift_reg;
        flags_next = flags_reg;
        ext_next   = ext_reg;
        sid_next   = sid_reg;
        len_next   = len_reg;
        ver_next   = ver_reg;
        hdl_next   = hdl_reg;
        trick_next = trick_reg;
        crc_next   = crc_reg;
        pts_next   = pts_reg;
        dts_next   = dts_reg;
        escr_next  = escr_reg;
        escx_next  = escx_reg;
        rate_next  = rate_reg;
        emit       = 1'b0;
        st         = ST_OK;
        go_next    = 1'b0;
        go_from    = phase_reg;
        m1_flag    = 1'b0;
        group_end  = 1'b0;
        hdl_m1     = hdl_reg;
        none       = 1'b0;
        np         = PH_IDLE;

        if (beat) begin
            if (in_data.first_byte) begin
                phase_next = PH_SC1;
                cnt_next   = '0;
                skip_next  = '0;
                shift_next = '0;
                flags_next = '0;
                ext_next   = '0;
                sid_next   = '0;
                len_next   = '0;
                ver_next   = '0;
                hdl_next   = '0;
                trick_next = '0;
                crc_next   = '0;
                pts_next   = '0;
                dts_next   = '0;
                escr_next  = '0;
                escx_next  = '0;
                rate_next  = '0;
            end else begin
                case (phase_reg)
                    PH_IDLE: ;
                    PH_SC1:  phase_next = PH_SC2;
                    PH_SC2:  phase_next = PH_SID;
                    PH_SID: begin
                        sid_next   = b;
                        phase_next = PH_LENH;
                    end
                    PH_LENH: begin
                        shift_next = {40'd0, b};
                        phase_next = PH_LENL;
                    end
                    PH_LENL: begin
                        len_next   = {shift_reg[7:0], b};
                        shift_next = '0;
                        if (!regular_stream(sid_reg)) begin
                            emit = 1'b1;
                            st   = ST_NOOPT;
                        end else begin
                            phase_next = PH_OPT0;
                        end
                    end
                    PH_OPT0: begin
                        if (b[7]) begin
                            ver_next = VER_MPEG2;
                            if (b[6]) begin
                                emit = 1'b1;
                                st   = ST_MARKER;
                            end else begin
                                flags_next = {b[5:0], 8'd0};
                                phase_next = PH_OPT1;
                            end
                        end else begin
                            ver_next = VER_MPEG1;
                            if (b == 8'hFF) begin
                                hdl_next   = hdl_sat(hdl_reg, 4'd1);
                                phase_next = PH_M1A;
                            end else if (b[7:6] == 2'b01) begin
                                hdl_next   = hdl_sat(hdl_reg, 4'd2);
                                phase_next = PH_M1STD;
                            end else begin
                                m1_flag = 1'b1;
                            end
                        end
                    end
                    PH_M1A: begin
                        if (b == 8'hFF) begin
                            hdl_next = hdl_sat(hdl_reg, 4'd1);
                        end else if (b[7:6] == 2'b01) begin
                            hdl_next   = hdl_sat(hdl_reg, 4'd2);
                            phase_next = PH_M1STD;
                        end else begin
                            m1_flag = 1'b1;
                        end
                    end
                    PH_M1STD: phase_next = PH_M1C;
                    PH_M1C:   m1_flag = 1'b1;
                    PH_OPT1: begin
                        flags_next = flags_reg | {6'd0, b};
                        phase_next = PH_HDL;
                    end
                    PH_HDL: begin
                        hdl_next = b;
                        go_next  = 1'b1;
                        go_from  = PH_HDL;
                    end
                    default: begin
                        // field groups
                        shift_next = x;
                        cnt_next   = cnt_inc;
                        if (phase_reg == PH_PACKSKIP || phase_reg == PH_EXT2SKIP) begin
                            skip_next = skip_dec;
                            group_end = skip_dec == 8'd0;
                        end else begin
                            group_end = cnt_inc >= group_len(phase_reg);
                        end
                        if (group_end) begin
                            go_next = 1'b1;
                            case (phase_reg)
                                PH_PTS: begin
                                    if (!ts_ok) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end else begin
                                        pts_next = ts_val;
                                    end
                                end
                                PH_DTS: begin
                                    if (!ts_ok) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end else begin
                                        dts_next = ts_val;
                                    end
                                end
                                PH_ESCR: begin
                                    if (!(x[42] && x[26] && x[10] && x[0])) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end else begin
                                        escr_next = {x[45:43], x[41:27], x[25:11]};
                                        escx_next = x[9:1];
                                    end
                                end
                                PH_RATE: begin
                                    if (!(x[23] && x[0])) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end else begin
                                        rate_next = x[22:1];
                                    end
                                end
                                PH_TRICK: trick_next = x[7:0];
                                PH_COPY: begin
                                    if (!x[7]) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end
                                end
                                PH_CRC: crc_next = x[15:0];
                                PH_EXT: ext_next = x[7:0];
                                PH_PACKLEN: skip_next = x[7:0];
                                PH_SEQ: begin
                                    if (!(x[15] && x[7])) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end
                                end
                                PH_PSTD: begin
                                    if (x[15:14] != 2'b01) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end
                                end
                                PH_EXT2LEN: begin
                                    if (!x[7]) begin
                                        emit = 1'b1; st = ST_MARKER; go_next = 1'b0;
                                    end else begin
                                        skip_next = {1'b0, x[6:0]};
                                    end
                                end
                                default: ;
                            endcase
                        end
                    end
                endcase

                // mpeg-1 flag byte
                if (m1_flag) begin
                    if (b == 8'h0F) begin
                        hdl_next = hdl_sat(hdl_reg, 4'd1);
                        emit     = 1'b1;
                    end else if (b[7:6] != 2'b00) begin
                        emit = 1'b1;
                        st   = ST_MARKER;
                    end else begin
                        flags_next = {6'd0, m1pd, 6'd0};
                        if (m1pd[1]) begin
                            hdl_next   = hdl_sat(hdl_reg, m1pd[0] ? 4'd10 : 4'd5);
                            phase_next = PH_PTS;
                            shift_next = {40'd0, b};
                            cnt_next   = 5'd1;
                        end else begin
                            hdl_next = hdl_sat(hdl_reg, 4'd1);
                            emit     = 1'b1;
                            st       = (b[3:0] == 4'hF) ? ST_MARKER : ST_OK;
                        end
                    end
                    hdl_m1 = hdl_next;
                end

                // advance to the next wanted group or finish
                if (go_next) begin
                    cnt_next   = '0;
                    shift_next = '0;
                    np = next_phase(go_from, flags_next, ext_next, skip_next, none);
                    if (none) begin
                        emit = 1'b1;
                        st   = ST_OK;
                    end else begin
                        phase_next = np;
                    end
                end

                if (emit) begin
                    phase_next = PH_IDLE;
                end
            end
        end
    end

    // result assembled from next-state values
    always_comb begin
        logic bad;
        bad = st == ST_MARKER;
        emit_data.pes_sid            = sid_next;
        emit_data.pkt_len            = len_next;
        emit_data.syntax_version     = ver_next;
        emit_data.header_flags       = flags_next;
        emit_data.header_data_length = hdl_next;
        emit_data.pts                = bad ? '0 : pts_next;
        emit_data.dts                = bad ? '0 : dts_next;
        emit_data.clkref_base        = bad ? '0 : escr_next;
        emit_data.clkref_ext         = bad ? '0 : escx_next;
        emit_data.es_rate            = bad ? '0 : rate_next;
        emit_data.trick_and_crc      = bad ? '0 : {trick_next, crc_next};
        emit_data.status             = st;
    end

    // control state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg <= PH_IDLE;
            cnt_reg   <= '0;
            skip_reg  <= '0;
            flags_reg <= '0;
            ext_reg   <= '0;
        end else begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
            skip_reg  <= skip_next;
            flags_reg <= flags_next;
            ext_reg   <= ext_next;
        end
    end

    // field accumulators
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            shift_reg <= '0;
            sid_reg   <= '0;
            len_reg   <= '0;
            ver_reg   <= '0;
            hdl_reg   <= '0;
            trick_reg <= '0;
            crc_reg   <= '0;
            pts_reg   <= '0;
            dts_reg   <= '0;
            escr_reg  <= '0;
            escx_reg  <= '0;
            rate_reg  <= '0;
        end else begin
            shift_reg <= shift_next;
            sid_reg   <= sid_next;
            len_reg   <= len_next;
            ver_reg   <= ver_next;
            hdl_reg   <= (m1_flag) ? hdl_m1 : hdl_next;
            trick_reg <= trick_next;
            crc_reg   <= crc_next;
            pts_reg   <= pts_next;
            dts_reg   <= dts_next;
            escr_reg  <= escr_next;
            escx_reg  <= escx_next;
            rate_reg  <= rate_next;
        end
    end

endmodule

FILE: rtl/pes_header_parser_top.sv
// pes header parser: one byte beat per cycle in, at most one result beat per packet out
// result: registered, and presented in the cycle after the byte that ends the header
// throughput: one byte per cycle; input stalls only while a result waits unread
// reset: synchronous active-low aresetn returns the parser to idle with fields cleared
// depends on pesp_pkg, pesp_parser, pesp_out_reg

module pes_header_parser_top (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  pesp_pkg::pesp_in_t   s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output pesp_pkg::pesp_out_t  m_data
);
    import pesp_pkg::*;

    logic      beat;
    logic      emit;
    logic      full;
    pesp_out_t emit_data;

    assign s_ready = !full;
    assign beat    = s_valid && s_ready;

    // byte parser
    pesp_parser u_parser (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .beat      (beat),
        .in_data   (s_data),
        .emit      (emit),
        .emit_data (emit_data)
    );

    // result register
    pesp_out_reg u_out (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (emit),
        .load_data (emit_data),
        .full      (full),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    // a result only appears from an accepted byte
    property p_emit_from_beat;
        @(posedge aclk) disable iff (!aresetn) emit |-> beat;
    endproperty
    a_emit_from_beat: assert property (p_emit_from_beat) else $error("result without beat");

    // a result raises valid next cycle
    property p_emit_valid;
        @(posedge aclk) disable iff (!aresetn) emit |=> m_valid;
    endproperty
    a_emit_valid: assert property (p_emit_valid) else $error("result lost");

    // a status code is never three
    property p_status;
        @(posedge aclk) disable iff (!aresetn) m_valid |-> m_data.status != 2'd3;
    endproperty
    a_status: assert property (p_status) else $error("bad status");

endmodule

FILE: bench/pes_header_checker.sv
// pes_header_checker: watches both channels of the pes header parser,
// predicts each packet result and compares it field by field
// depends on pesp_pkg

module pes_header_checker (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    input  logic                s_ready,
    input  pesp_pkg::pesp_in_t  s_data,
    input  logic                m_valid,
    input  logic                m_ready,
    input  pesp_pkg::pesp_out_t m_data,
    output int                  fail_count,
    output int                  pending,
    output int                  results_seen,
    output int                  status_seen [3]
);
    timeunit 1ns;
    timeprecision 1ps;
    import pesp_pkg::*;

    // parse state of the predicted parser
    pesp_phase_t phase;
    logic        active;
    int          nbytes;
    int          skip_left;
    logic [47:0] shreg;
    logic [13:0] flags;
    logic [7:0]  ext_flags;
    pesp_out_t   acc;
    pesp_out_t   header_q[$];

    function automatic int bytes_per_group(pesp_phase_t p);
        case (p)
            PH_PTS, PH_DTS: return 5;
            PH_ESCR:        return 6;
            PH_RATE:        return 3;
            PH_CRC, PH_SEQ, PH_PSTD: return 2;
            PH_PRIV:        return 16;
            PH_TRICK, PH_COPY, PH_EXT, PH_PACKLEN, PH_EXT2LEN: return 1;
            default:        return 0;
        endcase
    endfunction

    function automatic logic is_regular(logic [7:0] sid);
        return !(sid inside {8'hBC, 8'hBE, 8'hBF, 8'hF0, 8'hF1, 8'hF2, 8'hF8, 8'hFF});
    endfunction

    function automatic logic group_wanted(pesp_phase_t p);
        case (p)
            PH_PTS:   return flags[7:6] >= 2;
            PH_DTS:   return flags[7:6] == 3;
            PH_ESCR:  return flags[5];
            PH_RATE:  return flags[4];
            PH_TRICK: return flags[3];
            PH_COPY:  return flags[2];
            PH_CRC:   return flags[1];
            PH_EXT:   return flags[0];
            PH_PRIV:  return ext_flags[7];
            PH_PACKLEN: return ext_flags[6];
            PH_SEQ:   return ext_flags[5];
            PH_PSTD:  return ext_flags[4];
            PH_EXT2LEN: return ext_flags[0];
            PH_PACKSKIP, PH_EXT2SKIP: return skip_left != 0;
            default:  return 1'b0;
        endcase
    endfunction

    task automatic add_hdl(int n);
        int s;
        s = acc.header_data_length + n;
        acc.header_data_length = (s > 255) ? 8'hFF : s[7:0];
    endtask

    task automatic finish_header(logic [1:0] st);
        pesp_out_t r;
        r = acc;
        r.header_flags = flags;
        r.status = st;
        if (st == ST_MARKER) begin
            r.pts = '0; r.dts = '0; r.clkref_base = '0;
            r.clkref_ext = '0; r.es_rate = '0; r.trick_and_crc = '0;
        end
        header_q.push_back(r);
        active = 1'b0;
    endtask

    // phases are one-hot in header order, so walk the bit positions
    task automatic advance_group(pesp_phase_t from);
        int p;
        pesp_phase_t q;
        nbytes = 0;
        shreg = '0;
        for (p = $clog2(from) + 1; p <= $clog2(PH_EXT2SKIP); p++) begin
            q = pesp_phase_t'(27'd1 << p);
            if (group_wanted(q)) begin
                phase = q;
                return;
            end
        end
        finish_header(ST_OK);
    endtask

    function automatic logic ts_ok(logic [47:0] x, logic [3:0] nib);
        return x[39:36] == nib && x[32] && x[16] && x[0];
    endfunction

    function automatic logic [32:0] ts_val(logic [47:0] x);
        return {x[35:33], x[31:17], x[15:1]};
    endfunction

    task automatic mpeg1_flag_byte(logic [7:0] b);
        if (b == 8'h0F) begin
            add_hdl(1);
            finish_header(ST_OK);
        end else if (b[7:6] != 2'b00) begin
            finish_header(ST_MARKER);
        end else begin
            flags = {6'd0, b[5:4], 6'd0};
            if (b[5]) begin
                add_hdl(b[4] ? 10 : 5);
                phase = PH_PTS;
                shreg = {40'd0, b};
                nbytes = 1;
            end else begin
                add_hdl(1);
                finish_header(b[3:0] == 4'hF ? ST_MARKER : ST_OK);
            end
        end
    endtask

    task automatic mpeg1_lead_byte(logic [7:0] b);
        if (b == 8'hFF) begin
            add_hdl(1);
            phase = PH_M1A;
        end else if (b[7:6] == 2'b01) begin
            add_hdl(2);
            phase = PH_M1STD;
        end else begin
            mpeg1_flag_byte(b);
        end
    endtask

    task automatic close_group(pesp_phase_t p, logic [47:0] x);
        case (p)
            PH_PTS: begin
                if (!ts_ok(x, {2'b00, flags[7:6]})) begin finish_header(ST_MARKER); return; end
                acc.pts = ts_val(x);
            end
            PH_DTS: begin
                if (!ts_ok(x, 4'h1)) begin finish_header(ST_MARKER); return; end
                acc.dts = ts_val(x);
            end
            PH_ESCR: begin
                if (!(x[42] && x[26] && x[10] && x[0])) begin
                    finish_header(ST_MARKER); return;
                end
                acc.clkref_base = {x[45:43], x[41:27], x[25:11]};
                acc.clkref_ext = x[9:1];
            end
            PH_RATE: begin
                if (!(x[23] && x[0])) begin finish_header(ST_MARKER); return; end
                acc.es_rate = x[22:1];
            end
            PH_TRICK: acc.trick_and_crc[23:16] = x[7:0];
            PH_COPY: if (!x[7]) begin finish_header(ST_MARKER); return; end
            PH_CRC: acc.trick_and_crc[15:0] = x[15:0];
            PH_EXT: ext_flags = x[7:0];
            PH_PACKLEN: skip_left = int'(x[7:0]);
            PH_SEQ: if (!(x[15] && x[7])) begin finish_header(ST_MARKER); return; end
            PH_PSTD: if (x[15:14] != 2'b01) begin finish_header(ST_MARKER); return; end
            PH_EXT2LEN: begin
                if (!x[7]) begin finish_header(ST_MARKER); return; end
                skip_left = int'(x[6:0]);
            end
            default: ;
        endcase
        advance_group(p);
    endtask

    // one accepted byte beat through the predicted parser
    task automatic parse_byte(logic [7:0] b, logic first);
        if (first) begin
            acc = '0; flags = '0; ext_flags = '0; shreg = '0;
            nbytes = 0; skip_left = 0;
            phase = PH_SC1; active = 1'b1;
            return;
        end
        if (!active) return;
        case (phase)
            PH_SC1: phase = PH_SC2;
            PH_SC2: phase = PH_SID;
            PH_SID: begin acc.pes_sid = b; phase = PH_LENH; end
            PH_LENH: begin shreg = {40'd0, b}; phase = PH_LENL; end
            PH_LENL: begin
                acc.pkt_len = {shreg[7:0], b};
                shreg = '0;
                if (!is_regular(acc.pes_sid)) finish_header(ST_NOOPT);
                else phase = PH_OPT0;
            end
            PH_OPT0: begin
                if (b[7]) begin
                    acc.syntax_version = VER_MPEG2;
                    if (b[6]) finish_header(ST_MARKER);
                    else begin flags = {b[5:0], 8'd0}; phase = PH_OPT1; end
                end else begin
                    acc.syntax_version = VER_MPEG1;
                    mpeg1_lead_byte(b);
                end
            end
            PH_OPT1: begin flags[7:0] = b; phase = PH_HDL; end
            PH_HDL: begin acc.header_data_length = b; advance_group(PH_HDL); end
            PH_M1A: mpeg1_lead_byte(b);
            PH_M1STD: phase = PH_M1C;
            PH_M1C: mpeg1_flag_byte(b);
            default: begin
                shreg = {shreg[39:0], b};
                nbytes++;
                if (phase == PH_PACKSKIP || phase == PH_EXT2SKIP) begin
                    if (skip_left != 0) skip_left--;
                    if (skip_left == 0) close_group(phase, shreg);
                end else if (nbytes >= bytes_per_group(phase)) begin
                    close_group(phase, shreg);
                end
            end
        endcase
    endtask

    always @(posedge aclk) begin
        pesp_out_t want;
        if (!aresetn) begin
            active = 1'b0;
            phase = PH_IDLE;
            header_q.delete();
            pending <= 0;
            fail_count <= 0;
            results_seen <= 0;
            status_seen <= '{0, 0, 0};
        end else begin
            // result beat against the oldest predicted header
            if (m_valid && m_ready) begin
                results_seen <= results_seen + 1;
                if (m_data.status < 3) status_seen[m_data.status] <= status_seen[m_data.status] + 1;
                if (header_q.size() == 0) begin
                    if (fail_count < 10) $display("unexpected result beat %p", m_data);
                    fail_count <= fail_count + 1;
                end else begin
                    want = header_q.pop_front();
                    if (want !== m_data) begin
                        if (fail_count < 10)
                            $display("result mismatch\n  expected %p\n  actual   %p",
                                     want, m_data);
                        fail_count <= fail_count + 1;
                    end
                end
            end
            if (s_valid && s_ready)
                parse_byte(s_data.data_byte, s_data.first_byte);
            pending <= header_q.size();
        end
    end
endmodule

FILE: bench/tb_pes_header_parser_top.sv
// tb_pes_header_parser_top: byte stimulus and verdict for the pes header parser
// depends on pesp_pkg, pes_header_parser_top and pes_header_checker

module tb_pes_header_parser_top;
    timeunit 1ns;
    timeprecision 1ps;
    import pesp_pkg::*;

    logic      aclk;
    logic      aresetn;
    logic      s_valid, s_ready, m_valid, m_ready;
    pesp_in_t  s_data;
    pesp_out_t m_data;
    int        fail_count, pending, results_seen;
    int        status_seen [3];
    int        send_idle_pct, recv_stall_pct;
    int        hold_off;
    int        beats_sent;
    logic [7:0] pkt[$];

    pes_header_parser_top dut (.*);

    pes_header_checker u_check (
        .aclk, .aresetn, .s_valid, .s_ready, .s_data, .m_valid, .m_ready, .m_data,
        .fail_count, .pending, .results_seen, .status_seen
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    initial begin
        #50ms;
        $display("pes_header_parser_top verification failed");
        $finish;
    end

    // receiver: random stall, plus a long hold-off when requested
    initial begin
        m_ready = 1'b0;
        forever begin
            @(negedge aclk);
            if (hold_off > 0) begin
                m_ready <= 1'b0;
                hold_off--;
            end else begin
                m_ready <= ($urandom_range(99) >= recv_stall_pct);
            end
        end
    end

    // valid stays up between back-to-back beats; it drops only in idle gaps
    task automatic send_beat(logic [7:0] b, logic first);
        while ($urandom_range(99) < send_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_data <= '{data_byte: b, first_byte: first};
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        beats_sent++;
        @(negedge aclk);
    endtask

    task automatic send_packet();
        int i;
        for (i = 0; i < pkt.size(); i++) send_beat(pkt[i], i == 0);
        pkt.delete();
    endtask

    // a timestamp group with the given leading nibble, markers set unless broken
    task automatic push_ts(logic [3:0] nib, logic [32:0] v, logic broken);
        logic [39:0] g;
        g = {nib, v[32:30], 1'b1, v[29:15], 1'b1, v[14:0], 1'b1};
        if (broken) g[$urandom_range(2) * 16] = 1'b0;
        for (int k = 4; k >= 0; k--) pkt.push_back(g[k*8 +: 8]);
    endtask

    function automatic logic [32:0] rnd33();
        return 33'({$urandom, $urandom});
    endfunction

    task automatic push_prefix(logic [7:0] sid);
        pkt.push_back(8'h00); pkt.push_back(8'h00); pkt.push_back(8'h01);
        pkt.push_back(sid);
        pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom));
    endtask

    // mpeg-2 header with random flags and well-formed fields (mostly)
    task automatic mpeg2_packet(logic [13:0] fl, logic bad);
        logic [47:0] e;
        logic [32:0] b;
        logic [7:0]  xf;
        int n;
        push_prefix(8'($urandom_range(8'hC0, 8'hEF)));
        pkt.push_back({2'b10, fl[13:8]});
        pkt.push_back(fl[7:0]);
        pkt.push_back(8'($urandom));
        if (fl[7]) push_ts(fl[6] ? 4'h3 : 4'h2, rnd33(), bad && $urandom_range(3) == 0);
        if (fl[7:6] == 2'b11) push_ts(4'h1, rnd33(), 1'b0);
        if (fl[5]) begin
            b = rnd33();
            e = {2'b00, b[32:30], 1'b1, b[29:15], 1'b1, b[14:0], 1'b1,
                 9'($urandom), !(bad && $urandom_range(3) == 0)};
            for (int k = 5; k >= 0; k--) pkt.push_back(e[k*8 +: 8]);
        end
        if (fl[4]) begin
            e[23:0] = {1'b1, 22'($urandom), 1'b1};
            for (int k = 2; k >= 0; k--) pkt.push_back(e[k*8 +: 8]);
        end
        if (fl[3]) pkt.push_back(8'($urandom));
        if (fl[2]) pkt.push_back({!(bad && $urandom_range(1)), 7'($urandom)});
        if (fl[1]) begin pkt.push_back(8'($urandom)); pkt.push_back(8'($urandom)); end
        if (fl[0]) begin
            xf = 8'($urandom);
            pkt.push_back(xf);
            if (xf[7]) repeat (16) pkt.push_back(8'($urandom));
            if (xf[6]) begin
                n = $urandom_range(4);
                pkt.push_back(8'(n));
                repeat (n) pkt.push_back(8'($urandom));
            end
            if (xf[5]) begin
                pkt.push_back({1'b1, 7'($urandom)});
                pkt.push_back({!(bad && $urandom_range(1)), 7'($urandom)});
            end
            if (xf[4]) begin
                pkt.push_back({2'b01, 6'($urandom)});
                pkt.push_back(8'($urandom));
            end
            if (xf[0]) begin
                n = $urandom_range(3);
                pkt.push_back({1'b1, 7'(n)});
                repeat (n) pkt.push_back(8'($urandom));
            end
        end
        repeat ($urandom_range(2)) pkt.push_back(8'hFF);
        send_packet();
    endtask

    // mpeg-1 header: stuffing, optional std, timestamp flag byte
    task automatic mpeg1_packet(logic bad);
        int pd;
        push_prefix(8'($urandom_range(8'hC0, 8'hEF)));
        repeat ($urandom_range(3)) pkt.push_back(8'hFF);
        if ($urandom_range(1)) begin
            pkt.push_back({2'b01, 6'($urandom)});
            pkt.push_back(8'($urandom));
        end
        pd = $urandom_range(3);
        if (pd == 0 && $urandom_range(1)) pkt.push_back(8'h0F);
        else if (pd < 2) pkt.push_back({2'b00, 2'(pd), bad ? 4'hF : 4'($urandom_range(14))});
        else begin
            push_ts(pd == 3 ? 4'h3 : 4'h2, rnd33(), bad);
            if (pd == 3) push_ts(4'h1, rnd33(), 1'b0);
        end
        send_packet();
    endtask

    task automatic noise_packet();
        int n;
        n = $urandom_range(1, 12);
        pkt.push_back(8'($urandom));
        repeat (n) pkt.push_back(8'($urandom));
        send_packet();
    endtask

    task automatic random_packets(int n);
        int pick;
        repeat (n) begin
            pick = $urandom_range(99);
            if (pick < 55) mpeg2_packet(14'($urandom), $urandom_range(7) == 0);
            else if (pick < 80) mpeg1_packet($urandom_range(5) == 0);
            else if (pick < 88) begin
                push_prefix(8'hBC); pkt.push_back(8'($urandom)); send_packet();
            end else noise_packet();
        end
    endtask

    initial begin
        s_valid = 1'b0;
        s_data = '0;
        aresetn = 1'b0;
        send_idle_pct = 0;
        recv_stall_pct = 0;
        hold_off = 0;
        beats_sent = 0;
        repeat (12) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: stray bytes, non-regular ids, bad version bits, extremes
        send_beat(8'hFF, 1'b0);
        send_beat(8'h00, 1'b0);
        push_prefix(8'hFF); send_packet();
        push_prefix(8'hBE); send_packet();
        push_prefix(8'hE0); pkt.push_back(8'hC0); send_packet();
        mpeg2_packet(14'h3FFF, 1'b0);
        mpeg2_packet(14'h0000, 1'b0);
        mpeg2_packet(14'h00C0, 1'b0);
        mpeg2_packet(14'h0040, 1'b0);
        mpeg2_packet(14'h00FF, 1'b1);
        mpeg1_packet(1'b0);
        mpeg1_packet(1'b1);
        // restart mid-packet abandons it
        push_prefix(8'hE0); pkt.push_back(8'h80); send_packet();
        // saturating mpeg-1 stuffing count
        push_prefix(8'hC0);
        repeat (260) pkt.push_back(8'hFF);
        pkt.push_back(8'h0F);
        send_packet();

        // long receiver hold-off while bytes keep being offered
        hold_off = 400;
        random_packets(4);

        random_packets(4);
        send_idle_pct = 52; random_packets(4);
        send_idle_pct = 0; recv_stall_pct = 52; random_packets(4);
        send_idle_pct = 18; recv_stall_pct = 18; random_packets(4);
        send_idle_pct = 0; recv_stall_pct = 0; random_packets(4);
        s_valid <= 1'b0;

        while (pending != 0) @(posedge aclk);
        repeat (20) @(posedge aclk);

        $display("sent %0d byte beats, checked %0d headers", beats_sent, results_seen);
        $display("status ok %0d, marker errors %0d, no optional header %0d",
                 status_seen[0], status_seen[1], status_seen[2]);
        if (fail_count == 0)
            $display("pes_header_parser_top verification clean");
        else
            $display("pes_header_parser_top verification failed");
        $finish;
    end
endmodule
